@@ hw/rtl/text_encoding_sniffer_core_assert.svh @@
// Assertion macros for the text encoding sniffer.
// Included by the top level; depends on nothing else.
`ifndef TEXT_ENCODING_SNIFFER_CORE_ASSERT_SVH
`define TEXT_ENCODING_SNIFFER_CORE_ASSERT_SVH

// Check that is switched off while reset is high
`define TES_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset
`define TES_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tes_pkg.sv @@
// Shared types, constants and per-byte and per-word check functions for the text encoding sniffer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

   // Guessed encoding codes
   localparam logic [1:0] ENC_MBCS     = 2'd0;
   localparam logic [1:0] ENC_UTF8     = 2'd1;
   localparam logic [1:0] ENC_UTF16_LE = 2'd2;
   localparam logic [1:0] ENC_UTF16_BE = 2'd3;

   // Byte-order marks, first byte in the lowest bits
   localparam logic [23:0] BOM_UTF8     = 24'hBFBBEF;
   localparam logic [15:0] BOM_UTF16_LE = 16'hFEFF;
   localparam logic [15:0] BOM_UTF16_BE = 16'hFFFE;

   // Surrogate ranges
   localparam logic [15:0] HI_SURR_LO = 16'hD800;
   localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LO_SURR_LO = 16'hDC00;
   localparam logic [15:0] LO_SURR_HI = 16'hDFFF;

   localparam int RSP_BITS = 16;

   // Running state of one UTF-16 reading
   typedef struct packed {
      logic ok;
      logic need;
      logic pairs;
   } word_chk_type;

   // Final view of a buffer, handed from the scanner to the verdict stage
   typedef struct packed {
      logic [23:0] head;
      logic [1:0]  seen;
      logic        fm;
      logic        f8;
      logic        fl;
      logic        fb;
      logic        pl;
      logic        pb;
   } scan_flags_type;

   // Number of continuation bytes announced by a UTF-8 lead byte
   function automatic logic [2:0] follow_count(logic [7:0] c);
      logic [2:0] n;
      n = 3'd0;
      if (c[7] == 1'b0)              n = 3'd0;
      else if (c[7:5] == 3'b110)     n = 3'd1;
      else if (c[7:4] == 4'b1110)    n = 3'd2;
      else if (c[7:3] == 5'b11110)   n = 3'd3;
      else if (c[7:2] == 6'b111110)  n = 3'd4;
      else if (c[7:1] == 7'b1111110) n = 3'd5;
      return n;
   endfunction

   // One 16-bit word through one UTF-16 reading
   function automatic word_chk_type word_step(logic [15:0] w, word_chk_type s);
      word_chk_type r;
      logic         is_hi;
      logic         is_lo;
      r     = s;
      is_hi = w inside {[HI_SURR_LO:HI_SURR_HI]};
      is_lo = w inside {[LO_SURR_LO:LO_SURR_HI]};
      if (s.ok) begin
         if (w == 16'h0000) begin
            r.ok = 1'b0;
         end else if (s.need) begin
            if (is_lo) r.need = 1'b0;
            else       r.ok   = 1'b0;
         end else if (is_hi) begin
            r.need  = 1'b1;
            r.pairs = 1'b1;
         end else if (is_lo) begin
            r.ok = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/text_encoding_sniffer_core.sv @@
// Top level of the text encoding sniffer: input register, scanner, verdict register.
// Depends on tes_pkg, tes_in_stage, tes_scan, tes_verdict and the assertion header.
//
//   channel | dir | payload                                 | marks
//   req     | in  | tdata[7:0] text_byte                    | tlast = last_byte
//   rsp     | out | tdata[15:0] result fields (see port)    | none
//
// One byte per cycle is taken while the result side keeps up.
// rsp_tvalid rises once the last byte has passed the input register and the verdict register has captured the result.
// A byte sits in the input register until it is consumed; the scan state updates from it.
// A last byte waits in the input register while an untaken result is held,
// which stalls req_tready. Synchronous reset clears the scan state and both valids.
`timescale 1ns / 1ps
`default_nettype none
`include "text_encoding_sniffer_core_assert.svh"

module text_encoding_sniffer_core
   import tes_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] text_byte
   input  wire logic                req_tlast,   // last_byte
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata    // [0] has_bom, [2:1] guessed_encoding,
                                                 // [3] ambiguous, [4] may_be_mbcs,
                                                 // [5] may_be_utf8, [6] may_be_utf16_le,
                                                 // [7] may_be_utf16_be, [8] pairs_seen_le,
                                                 // [9] pairs_seen_be, [15:10] zero
);

   logic           hold_valid;
   logic [7:0]     hold_byte;
   logic           hold_last;
   logic           advance;
   logic           load;
   scan_flags_type flags;

   // A byte moves on unless it ends a buffer and the result slot is full and not being taken
   assign advance = hold_valid && (!hold_last || !rsp_tvalid || rsp_tready);
   assign load    = advance && hold_last;

   tes_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte),
      .hold_last  (hold_last)
   );

   tes_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .text_byte (hold_byte),
      .last_byte (hold_last),
      .flags     (flags)
   );

   tes_verdict u_verdict (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .flags     (flags),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // A mark blanks every rough check and both pair flags
   `TES_ASSERT(a_bom_blanks, clock, reset, rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[9:3] == 7'd0, "mark result carries check flags")
   // Ambiguity means a zero guess and at least two checks passing
   `TES_ASSERT(a_amb_guess, clock, reset, rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2:1] == ENC_MBCS && $countones(rsp_tdata[7:4]) > 1, "ambiguous result inconsistent")
   // A new result only follows a consumed last byte
   `TES_ASSERT(a_rsp_source, clock, reset, $rose(rsp_tvalid) |-> $past(load), "result without a last byte")
   // A last byte is never consumed over an untaken result
   `TES_ASSERT_ALWAYS(a_no_overwrite, clock, load |-> !rsp_tvalid || rsp_tready, "result overwritten")

endmodule

`default_nettype wire

@@ hw/rtl/tes_in_stage.sv @@
// Input register of the text encoding sniffer: holds one byte transaction.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module tes_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   input  wire logic       advance,     // held byte is consumed this cycle
   output logic            hold_valid,
   output logic [7:0]      hold_byte,
   output logic            hold_last
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // Take a new byte whenever the slot is empty or being drained
   assign in_ready = !valid_ff || advance;
   assign valid_in = in_valid ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;
   assign hold_last  = last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tes_scan.sv @@
// Per-buffer scan state: head bytes, zero-byte, UTF-8 and UTF-16 checks.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tes_scan
   import tes_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,   // a byte is consumed this cycle
   input  wire logic [7:0] text_byte,
   input  wire logic       last_byte,
   output scan_flags_type  flags      // buffer view including this byte
);

   logic [23:0]  head_ff,   head_in;
   logic [1:0]   seen_ff,   seen_in;
   logic         odd_ff,    odd_in;
   logic [7:0]   held_ff,   held_in;
   logic         mbcs_ff,   mbcs_in;
   logic         u8ok_ff,   u8ok_in;
   logic [2:0]   u8pend_ff, u8pend_in;
   word_chk_type le_ff,     le_in;
   word_chk_type be_ff,     be_in;

   // Next state after this byte
   always_comb begin
      head_in   = head_ff;
      seen_in   = seen_ff;
      odd_in    = !odd_ff;
      held_in   = held_ff;
      mbcs_in   = mbcs_ff && (text_byte != 8'h00);
      u8ok_in   = u8ok_ff;
      u8pend_in = u8pend_ff;
      le_in     = le_ff;
      be_in     = be_ff;

      // first three bytes are kept for mark detection
      case (seen_ff)
         2'd0:    begin head_in[7:0]   = text_byte; seen_in = 2'd1; end
         2'd1:    begin head_in[15:8]  = text_byte; seen_in = 2'd2; end
         2'd2:    begin head_in[23:16] = text_byte; seen_in = 2'd3; end
         default: begin end
      endcase

      // UTF-8 structure
      if (u8ok_ff) begin
         if (u8pend_ff != 3'd0) begin
            if (text_byte[7:6] != 2'b10) u8ok_in   = 1'b0;
            else                         u8pend_in = u8pend_ff - 3'd1;
         end else if (text_byte == 8'h00) begin
            u8ok_in = 1'b0;
         end else begin
            u8pend_in = follow_count(text_byte);
         end
      end

      // UTF-16 words complete on every second byte
      if (odd_ff) begin
         le_in = word_step({text_byte, held_ff}, le_ff);
         be_in = word_step({held_ff, text_byte}, be_ff);
      end else begin
         held_in = text_byte;
      end
   end

   // Final view, valid when this byte ends the buffer
   always_comb begin
      flags.head = head_in;
      flags.seen = seen_in;
      flags.fm   = mbcs_in;
      flags.f8   = u8ok_in && (u8pend_in == 3'd0);
      flags.fl   = le_in.ok && !odd_in && !le_in.need;
      flags.fb   = be_in.ok && !odd_in && !be_in.need;
      flags.pl   = !odd_in && le_in.pairs;
      flags.pb   = !odd_in && be_in.pairs;
   end

   // State clears at reset and after the last byte of a buffer
   always_ff @(posedge clock) begin
      if (reset || (advance && last_byte)) begin
         head_ff   <= '0;
         seen_ff   <= '0;
         odd_ff    <= 1'b0;
         held_ff   <= '0;
         mbcs_ff   <= 1'b1;
         u8ok_ff   <= 1'b1;
         u8pend_ff <= '0;
         le_ff     <= '{ok: 1'b1, need: 1'b0, pairs: 1'b0};
         be_ff     <= '{ok: 1'b1, need: 1'b0, pairs: 1'b0};
      end else if (advance) begin
         head_ff   <= head_in;
         seen_ff   <= seen_in;
         odd_ff    <= odd_in;
         held_ff   <= held_in;
         mbcs_ff   <= mbcs_in;
         u8ok_ff   <= u8ok_in;
         u8pend_ff <= u8pend_in;
         le_ff     <= le_in;
         be_ff     <= be_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/tes_verdict.sv @@
// Mark detection, encoding guess and the result register.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tes_verdict
   import tes_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,        // last byte consumed, capture result
   input  wire scan_flags_type flags,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [RSP_BITS-1:0] out_data
);

   logic        valid_ff;
   logic        valid_in;
   logic [9:0]  res_ff;
   logic [9:0]  res_in;
   logic        bom;
   logic [1:0]  bom_enc;
   logic [1:0]  guess;
   logic        amb;
   logic [2:0]  cnt;

   // Byte-order mark, tested UTF-8 first
   always_comb begin
      bom     = 1'b0;
      bom_enc = ENC_MBCS;
      if (flags.seen == 2'd3 && flags.head == BOM_UTF8) begin
         bom = 1'b1; bom_enc = ENC_UTF8;
      end else if (flags.seen >= 2'd2 && flags.head[15:0] == BOM_UTF16_LE) begin
         bom = 1'b1; bom_enc = ENC_UTF16_LE;
      end else if (flags.seen >= 2'd2 && flags.head[15:0] == BOM_UTF16_BE) begin
         bom = 1'b1; bom_enc = ENC_UTF16_BE;
      end
   end

   // Guess from the mark, or from the rough checks when no mark is present
   always_comb begin
      cnt   = {2'b00, flags.fm} + {2'b00, flags.f8} + {2'b00, flags.fl}
            + {2'b00, flags.fb};
      amb   = 1'b0;
      guess = ENC_MBCS;
      if (bom) begin
         guess = bom_enc;
      end else if (cnt == 3'd1) begin
         if (flags.f8)      guess = ENC_UTF8;
         else if (flags.fl) guess = ENC_UTF16_LE;
         else if (flags.fb) guess = ENC_UTF16_BE;
      end else if (cnt > 3'd1) begin
         amb = 1'b1;
      end
   end

   // Fields from the highest bit down
   assign res_in = {flags.pb & !bom, flags.pl & !bom, flags.fb & !bom,
                    flags.fl & !bom, flags.f8 & !bom, flags.fm & !bom,
                    amb, guess, bom};

   assign valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = {{(RSP_BITS - 10){1'b0}}, res_ff};

endmodule

`default_nettype wire
